[design/vfd_mux_pwm_filament_driver_assert.svh]
// ----------------------------------------------------------------------------
// vfd_mux_pwm_filament_driver_assert.svh
// assertion macros for the display driver, sampled on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef VFD_MUX_PWM_FILAMENT_DRIVER_ASSERT_SVH
`define VFD_MUX_PWM_FILAMENT_DRIVER_ASSERT_SVH

// same-cycle implication
`define VFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/vfd_pkg.sv]
// ----------------------------------------------------------------------------
// vfd_pkg
// types and constants shared by the multiplexed display driver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vfd_pkg;

  localparam int DIGIT_W  = 2;
  localparam int SEG_W    = 8;
  localparam int WORD_W   = 16;
  localparam int BRIGHT_W = 6;
  localparam int FIL_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET  = 6'd30;
  localparam logic [FIL_W-1:0]    FIL_DIV_RESET = 16'd200;

  // item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIL_DIV    = 1'b1;

  // fixed digit select bits
  localparam logic [WORD_W-1:0] SELECT_BITS [4] = '{
    16'h2000, 16'h1000, 16'h4000, 16'h8000
  };

  typedef struct packed {
    logic               op;
    logic [DIGIT_W-1:0] digit_index;
    logic [SEG_W-1:0]   digit_segments;
  } in_item_t;

  typedef struct packed {
    logic              filament_level;
    logic              frame_valid;
    logic [WORD_W-1:0] frame_word;
    logic              blank_valid;
  } out_item_t;

  typedef struct packed {
    logic              frame_valid;
    logic [WORD_W-1:0] frame_word;
    logic              blank_valid;
  } scan_t;

endpackage

[design/vfd_scan.sv]
// ----------------------------------------------------------------------------
// vfd_scan
// digit store, pwm slot and digit counters, frame and blank decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vfd_scan #(
  parameter int DIGITS        = 4,
  parameter int PWM_SLOTS_MAX = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  logic                                wr_i,
  input  logic [vfd_pkg::DIGIT_W-1:0]         wr_idx_i,
  input  logic [vfd_pkg::SEG_W-1:0]           wr_seg_i,
  input  logic [vfd_pkg::BRIGHT_W-1:0]        brightness_i,
  output vfd_pkg::scan_t                      scan_o
);

  localparam int SLOT_W = $clog2(PWM_SLOTS_MAX + 2);
  localparam int CMP_W  = (SLOT_W > vfd_pkg::BRIGHT_W) ? SLOT_W : vfd_pkg::BRIGHT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PWM_SLOTS_MAX);

  logic [SLOT_W-1:0]            slot_q, slot_d, slot_cur;
  logic [vfd_pkg::DIGIT_W-1:0]  digit_q, digit_d, digit_inc;
  logic [vfd_pkg::SEG_W-1:0]    store_q [DIGITS];
  logic [vfd_pkg::SEG_W-1:0]    seg;
  logic                         wrap;

  always_comb begin
    wrap      = slot_q > SLOT_LAST;
    slot_cur  = wrap ? '0 : slot_q;
    digit_inc = digit_q + 1'b1;
    digit_d   = digit_q;
    if (wrap) begin
      digit_d = ({1'b0, digit_inc} >= (vfd_pkg::DIGIT_W + 1)'(DIGITS)) ? '0 : digit_inc;
    end
    slot_d = slot_cur + 1'b1;
    seg = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (digit_d == vfd_pkg::DIGIT_W'(i)) begin
        seg = store_q[i];
      end
    end
    scan_o.frame_valid = (slot_cur == '0);
    scan_o.frame_word  = scan_o.frame_valid ?
                         (vfd_pkg::SELECT_BITS[digit_d] |
                          {{(vfd_pkg::WORD_W - vfd_pkg::SEG_W){1'b0}}, seg}) : '0;
    scan_o.blank_valid = CMP_W'(slot_cur) >= CMP_W'(brightness_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      digit_q <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (tick_i) begin
        slot_q  <= slot_d;
        digit_q <= digit_d;
      end
      for (int i = 0; i < DIGITS; i++) begin
        if (wr_i && wr_idx_i == vfd_pkg::DIGIT_W'(i)) begin
          store_q[i] <= wr_seg_i;
        end
      end
    end
  end

endmodule

[design/vfd_mux_pwm_filament_driver.sv]
// ----------------------------------------------------------------------------
// vfd_mux_pwm_filament_driver
// multiplexed display driver with pwm dimming and filament clock
// ----------------------------------------------------------------------------
// Takes one item per clock cycle. A tick item yields one result item in the
// output register on the next cycle; a write item only updates the digit
// store and yields nothing. All counter and store updates finish in the
// accepting cycle, so the only limit on rate is the output register: while
// it holds an untaken result, a new item is taken in the same cycle that
// result leaves.
`timescale 1ns / 1ps

module vfd_mux_pwm_filament_driver #(
  parameter int DIGITS        = 4,
  parameter int PWM_SLOTS_MAX = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  vfd_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output vfd_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [vfd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [vfd_pkg::CFG_W-1:0]            cfg_wdata_i
);

  `include "vfd_mux_pwm_filament_driver_assert.svh"

  logic [vfd_pkg::BRIGHT_W-1:0] bright_q;
  logic [vfd_pkg::FIL_W-1:0]    fil_div_q;
  logic [vfd_pkg::FIL_W:0]      fil_cnt_q, fil_cnt_d, fil_inc;
  logic                         fil_on_q, fil_on_d;
  logic                         out_valid_q;
  vfd_pkg::out_item_t           out_q;
  vfd_pkg::scan_t               scan;
  logic                         in_acc, tick, wr;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign tick        = in_acc && (in_data_i.op == vfd_pkg::OP_TICK);
  assign wr          = in_acc && (in_data_i.op == vfd_pkg::OP_WRITE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  vfd_scan #(
    .DIGITS        (DIGITS),
    .PWM_SLOTS_MAX (PWM_SLOTS_MAX)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .wr_i         (wr),
    .wr_idx_i     (in_data_i.digit_index),
    .wr_seg_i     (in_data_i.digit_segments),
    .brightness_i (bright_q),
    .scan_o       (scan)
  );

  // filament divider
  always_comb begin
    fil_inc   = fil_cnt_q + 1'b1;
    fil_cnt_d = fil_inc;
    fil_on_d  = fil_on_q;
    if (fil_inc > {1'b0, fil_div_q}) begin
      fil_cnt_d = '0;
      fil_on_d  = !fil_on_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= vfd_pkg::BRIGHT_RESET;
      fil_div_q   <= vfd_pkg::FIL_DIV_RESET;
      fil_cnt_q   <= '0;
      fil_on_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vfd_pkg::REG_BRIGHTNESS: bright_q  <= cfg_wdata_i[vfd_pkg::BRIGHT_W-1:0];
          vfd_pkg::REG_FIL_DIV:    fil_div_q <= cfg_wdata_i[vfd_pkg::FIL_W-1:0];
          default: ;
        endcase
      end
      if (tick) begin
        fil_cnt_q <= fil_cnt_d;
        fil_on_q  <= fil_on_d;
      end
      if (in_acc) begin
        out_valid_q <= tick;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q.filament_level <= fil_on_d;
      out_q.frame_valid    <= scan.frame_valid;
      out_q.frame_word     <= scan.frame_word;
      out_q.blank_valid    <= scan.blank_valid;
    end
  end

  `VFD_ASSERT_NEXT(a_write_no_result, wr, !out_valid_o, "write item produced a result")
  `VFD_ASSERT_NEXT(a_tick_result, tick, out_valid_o, "tick item produced no result")
  `VFD_ASSERT_NOW(a_frame_word, out_valid_o,
                  out_data_o.frame_valid == (out_data_o.frame_word != '0),
                  "frame word disagrees with frame flag")

endmodule
